@@ src/e2q_pkg.sv @@
// e2q_pkg: shared widths, fixed-point constants, arctangent table and beat types
`default_nettype none

package e2q_pkg;

    // field widths of the angle and quaternion beats
    localparam int ANGLE_W  = 16;
    localparam int RESULT_W = 16;

    // q30 sine / cosine / product width, and wider cordic working width
    localparam int Q_W = 32;
    localparam int H_W = 34;

    localparam logic signed [H_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [H_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [H_W-1:0] Q30_GAIN    = 34'sd652032874;

    typedef logic signed [Q_W-1:0] t_q30;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [RESULT_W-1:0] quat_w;
        logic signed [RESULT_W-1:0] quat_x;
        logic signed [RESULT_W-1:0] quat_y;
        logic signed [RESULT_W-1:0] quat_z;
    } t_quat;

    // half-angle sine and cosine out of one lane
    typedef struct packed {
        t_q30 sin_val;
        t_q30 cos_val;
    } t_sc;

    // atan(2^-i) in q30, rounded toward zero
    function automatic logic signed [H_W-1:0] atan_q30(input int idx);
        logic signed [H_W-1:0] v;
        case (idx)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd7;
            28: v = 34'sd3;
            29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/e2q_cordic_lane.sv @@
// e2q_cordic_lane: quadrant fold and pipelined cordic giving half-angle sine and cosine
`default_nettype none

module e2q_cordic_lane #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_angle,
    output e2q_pkg::t_sc                       o_sc
);
    import e2q_pkg::*;

    localparam int SHIFT_IN = 32 - ANGLE_W;

    logic signed [H_W-1:0] r_x [CORDIC_STEPS+1];
    logic signed [H_W-1:0] r_y [CORDIC_STEPS+1];
    logic signed [H_W-1:0] r_h [CORDIC_STEPS+1];
    logic                  r_fold [CORDIC_STEPS+1];

    logic signed [H_W-1:0] n_x [CORDIC_STEPS+1];
    logic signed [H_W-1:0] n_y [CORDIC_STEPS+1];
    logic signed [H_W-1:0] n_h [CORDIC_STEPS+1];
    logic                  n_fold [CORDIC_STEPS+1];

    logic signed [H_W-1:0] w_h_in;
    t_sc                   r_sc;

    // half angle in q30
    assign w_h_in = H_W'(i_angle) <<< SHIFT_IN;

    always_comb begin
        // fold into [-pi/2, pi/2]
        n_x[0] = Q30_GAIN;
        n_y[0] = '0;
        if (w_h_in > Q30_HALF_PI) begin
            n_h[0]    = w_h_in - Q30_PI;
            n_fold[0] = 1'b1;
        end else if (w_h_in < -Q30_HALF_PI) begin
            n_h[0]    = w_h_in + Q30_PI;
            n_fold[0] = 1'b1;
        end else begin
            n_h[0]    = w_h_in;
            n_fold[0] = 1'b0;
        end
        // one rotation per stage
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (!r_h[i][H_W-1]) begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_h[i+1] = r_h[i] - atan_q30(i);
            end else begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_h[i+1] = r_h[i] + atan_q30(i);
            end
            n_fold[i+1] = r_fold[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= CORDIC_STEPS; i++) begin
                r_x[i]    <= n_x[i];
                r_y[i]    <= n_y[i];
                r_h[i]    <= n_h[i];
                r_fold[i] <= n_fold[i];
            end
            // undo the fold by negating both
            if (r_fold[CORDIC_STEPS]) begin
                r_sc.sin_val <= Q_W'(-r_y[CORDIC_STEPS]);
                r_sc.cos_val <= Q_W'(-r_x[CORDIC_STEPS]);
            end else begin
                r_sc.sin_val <= Q_W'(r_y[CORDIC_STEPS]);
                r_sc.cos_val <= Q_W'(r_x[CORDIC_STEPS]);
            end
        end
    end

    assign o_sc = r_sc;

endmodule

`default_nettype wire

@@ src/e2q_merge.sv @@
// e2q_merge: triple products of the three lanes, sums, rounding and saturation
`default_nettype none

module e2q_merge (
    input  logic          i_clk,
    input  logic          i_en,
    input  e2q_pkg::t_sc  i_roll,
    input  e2q_pkg::t_sc  i_pitch,
    input  e2q_pkg::t_sc  i_yaw,
    output e2q_pkg::t_quat o_quat
);
    import e2q_pkg::*;

    localparam int P_W = 2 * Q_W;
    localparam int S_W = Q_W + 2;
    localparam int SH  = 32 - RESULT_W;
    localparam logic signed [P_W-1:0] RND30   = P_W'(1) <<< 29;
    localparam logic signed [S_W-1:0] RND_OUT = (S_W'(1) <<< SH) >>> 1;
    localparam logic signed [S_W-1:0] LIM     = S_W'(1) <<< (RESULT_W - 2);

    // q30 product rounded half up
    function automatic t_q30 mul_rnd(input t_q30 a, input t_q30 b);
        logic signed [P_W-1:0] p;
        p = P_W'(a) * P_W'(b) + RND30;
        return Q_W'(p >>> 30);
    endfunction

    function automatic logic signed [RESULT_W-1:0] to_res(input t_q30 a, input t_q30 b,
                                                          input logic sub);
        logic signed [S_W-1:0] v;
        logic signed [S_W-1:0] r;
        v = sub ? (S_W'(a) - S_W'(b)) : (S_W'(a) + S_W'(b));
        r = (v + RND_OUT) >>> SH;
        if (r > LIM) begin
            r = LIM;
        end else if (r < -LIM) begin
            r = -LIM;
        end
        return RESULT_W'(r);
    endfunction

    // roll x pitch stage
    t_q30 r_cc, r_ss, r_sc, r_cs;
    t_sc  r_yaw;
    // times yaw stage
    t_q30 r_ccc, r_sss, r_scc, r_css, r_csc, r_scs, r_ccs, r_ssc;
    t_quat r_quat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc  <= mul_rnd(i_roll.cos_val, i_pitch.cos_val);
            r_ss  <= mul_rnd(i_roll.sin_val, i_pitch.sin_val);
            r_sc  <= mul_rnd(i_roll.sin_val, i_pitch.cos_val);
            r_cs  <= mul_rnd(i_roll.cos_val, i_pitch.sin_val);
            r_yaw <= i_yaw;

            r_ccc <= mul_rnd(r_cc, r_yaw.cos_val);
            r_sss <= mul_rnd(r_ss, r_yaw.sin_val);
            r_scc <= mul_rnd(r_sc, r_yaw.cos_val);
            r_css <= mul_rnd(r_cs, r_yaw.sin_val);
            r_csc <= mul_rnd(r_cs, r_yaw.cos_val);
            r_scs <= mul_rnd(r_sc, r_yaw.sin_val);
            r_ccs <= mul_rnd(r_cc, r_yaw.sin_val);
            r_ssc <= mul_rnd(r_ss, r_yaw.cos_val);

            r_quat.quat_w <= to_res(r_ccc, r_sss, 1'b0);
            r_quat.quat_x <= to_res(r_scc, r_css, 1'b1);
            r_quat.quat_y <= to_res(r_csc, r_scs, 1'b0);
            r_quat.quat_z <= to_res(r_ccs, r_ssc, 1'b1);
        end
    end

    assign o_quat = r_quat;

endmodule

`default_nettype wire

@@ src/euler_to_quaternion.sv @@
// euler_to_quaternion: z-y-x euler angles to unit quaternion, fully pipelined
// throughput: one beat per cycle; the whole pipeline holds while an output beat waits
// the cordic lanes and the merge multipliers advance on one shared enable
// reset: synchronous active-low, clears only the valid pipeline; data registers keep
// whatever they hold and are qualified by the valid bits
`default_nettype none

module euler_to_quaternion #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  e2q_pkg::t_angles i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output e2q_pkg::t_quat   o_out_data
);
    import e2q_pkg::*;

    // lane: fold register, one register per cordic step, sign-fix register
    // merge: roll x pitch, times yaw, sum and saturate
    localparam int LAT = CORDIC_STEPS + 5;

    logic           w_en;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    t_sc            w_roll_sc;
    t_sc            w_pitch_sc;
    t_sc            w_yaw_sc;

    // advance unless the last stage holds a beat nobody takes
    assign w_en       = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = w_en;
    assign o_out_valid = r_vld[LAT-1];

    // a new beat enters the valid chain exactly when it is accepted
    assign n_vld = w_en ? {r_vld[LAT-2:0], i_in_valid} : r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // one cordic lane per angle, side by side
    e2q_cordic_lane #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lane_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in_data.roll_angle),
        .o_sc    (w_roll_sc)
    );

    e2q_cordic_lane #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lane_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in_data.pitch_angle),
        .o_sc    (w_pitch_sc)
    );

    e2q_cordic_lane #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lane_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in_data.yaw_angle),
        .o_sc    (w_yaw_sc)
    );

    // combine the half-angle sines and cosines into w, x, y, z
    e2q_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_roll  (w_roll_sc),
        .i_pitch (w_pitch_sc),
        .i_yaw   (w_yaw_sc),
        .o_quat  (o_out_data)
    );

endmodule

`default_nettype wire

@@ src/e2q_checker.sv @@
// e2q_checker: port-level assertions for euler_to_quaternion, bound to the top level
`default_nettype none

module e2q_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input e2q_pkg::t_quat   o_out_data
);
    import e2q_pkg::*;

    localparam logic signed [RESULT_W-1:0] LIM = RESULT_W'(1) <<< (RESULT_W - 2);

    // a stalled output beat stays
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    // input side is only held back by a waiting output beat
    a_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output backpressure");

    // nothing comes out right after reset
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // quaternion parts stay within plus or minus one
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.quat_w <= LIM) && (o_out_data.quat_w >= -LIM)
                     && (o_out_data.quat_x <= LIM) && (o_out_data.quat_x >= -LIM)
                     && (o_out_data.quat_y <= LIM) && (o_out_data.quat_y >= -LIM)
                     && (o_out_data.quat_z <= LIM) && (o_out_data.quat_z >= -LIM))
        else $error("quaternion part out of range");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);

`default_nettype wire

@@ dv/euler_to_quaternion_test.sv @@
// euler_to_quaternion_test: self-checking bench for the euler angle to quaternion pipeline
`timescale 1ns / 100ps

module euler_to_quaternion_test;
    import e2q_pkg::*;

    localparam int PIPE_LATENCY     = 21;
    localparam int ITEMS_PER_PHASE  = 530;
    localparam int LONG_HOLD_AFTER  = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT      = 20000;

    // fixed-point constants of the half-angle cordic, q30 in 64 bits
    localparam int     CORDIC_ITERS = 16;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint GAIN_Q30     = 64'sd652032874;
    localparam longint ATAN_Q30 [CORDIC_ITERS] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
        64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767
    };

    class quat_scoreboard;
        t_quat       expected_quats[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // q30 product, rounded half up
        function longint mul_q30(longint a, longint b);
            return (a * b + (longint'(1) <<< 29)) >>> 30;
        endfunction

        function void half_sin_cos(input logic signed [ANGLE_W-1:0] ang,
                                   output longint s, output longint c);
            longint h, x, y, dx, dy;
            bit     flip;
            h    = longint'(ang) <<< (32 - ANGLE_W);
            x    = GAIN_Q30;
            y    = 0;
            flip = 1'b0;
            // fold into the right half plane, negate sine and cosine afterwards
            if (h > HALF_PI_Q30) begin
                h    = h - PI_Q30;
                flip = 1'b1;
            end else if (h < -HALF_PI_Q30) begin
                h    = h + PI_Q30;
                flip = 1'b1;
            end
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (h >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    h = h - ATAN_Q30[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    h = h + ATAN_Q30[i];
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        // round q30 sum to q1.14 and clamp to +-1.0
        function logic signed [RESULT_W-1:0] quat_part(longint v);
            longint r, lim;
            lim = longint'(1) <<< (RESULT_W - 2);
            r   = (v + (longint'(1) <<< (31 - RESULT_W))) >>> (32 - RESULT_W);
            if (r > lim)
                r = lim;
            if (r < -lim)
                r = -lim;
            return r[RESULT_W-1:0];
        endfunction

        function t_quat predict_quat(t_angles ang);
            longint sr, cr, sp, cp, sy, cy;
            t_quat  q;
            half_sin_cos(ang.roll_angle, sr, cr);
            half_sin_cos(ang.pitch_angle, sp, cp);
            half_sin_cos(ang.yaw_angle, sy, cy);
            q.quat_w = quat_part(mul_q30(mul_q30(cr, cp), cy) + mul_q30(mul_q30(sr, sp), sy));
            q.quat_x = quat_part(mul_q30(mul_q30(sr, cp), cy) - mul_q30(mul_q30(cr, sp), sy));
            q.quat_y = quat_part(mul_q30(mul_q30(cr, sp), cy) + mul_q30(mul_q30(sr, cp), sy));
            q.quat_z = quat_part(mul_q30(mul_q30(cr, cp), sy) - mul_q30(mul_q30(sr, sp), cy));
            return q;
        endfunction

        function void note_angles(t_angles ang);
            expected_quats.push_back(predict_quat(ang));
        endfunction

        function void compare_field(string name, logic signed [RESULT_W-1:0] want,
                                    logic signed [RESULT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_quat(t_quat got);
            t_quat want;
            if (expected_quats.size() == 0) begin
                $error("quaternion beat with nothing expected: %h", got);
                mismatches++;
                return;
            end
            want = expected_quats.pop_front();
            compare_field("quat_w", want.quat_w, got.quat_w);
            compare_field("quat_x", want.quat_x, got.quat_x);
            compare_field("quat_y", want.quat_y, got.quat_y);
            compare_field("quat_z", want.quat_z, got.quat_z);
        endfunction
    endclass

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    o_in_ready;
    t_angles i_in_data   = '0;
    logic    o_out_valid;
    logic    i_out_ready = 1'b0;
    t_quat   o_out_data;

    int send_idle_pct = 25;
    int recv_idle_pct = 64;

    quat_scoreboard quat_board = new();

    always #5 i_clk = ~i_clk;

    euler_to_quaternion #(
        .CORDIC_STEPS(CORDIC_ITERS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // every accepted quaternion beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            quat_board.check_quat(o_out_data);
    end

    // output side: random stalls plus one long hold so the pipeline backs up
    initial begin : out_side
        int hold_left;
        int beats_taken;
        bit hold_done;
        hold_left   = 0;
        beats_taken = 0;
        hold_done   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                beats_taken++;
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && beats_taken >= LONG_HOLD_AFTER) begin
                hold_left = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [ANGLE_W-1:0] random_angle();
        int v;
        case ($urandom_range(9))
            6: begin
                // around the quadrant fold at +-pi
                v = 25732 + int'($urandom_range(8));
                if ($urandom_range(1))
                    v = -v;
            end
            7: v = int'($urandom_range(512)) - 256;
            8: begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 12868;
                    default: v = -12868;
                endcase
            end
            9: v = int'($urandom_range(6)) - 3;
            default: v = int'($urandom);
        endcase
        return v[ANGLE_W-1:0];
    endfunction

    function automatic t_angles corner_angles(int idx);
        t_angles ang;
        case (idx)
            0:  ang = '{16'sd0, 16'sd0, 16'sd0};
            1:  ang = '{16'sd32767, 16'sd32767, 16'sd32767};
            2:  ang = '{16'sh8000, 16'sh8000, 16'sh8000};
            3:  ang = '{16'sd32767, 16'sd0, 16'sd0};
            4:  ang = '{16'sh8000, 16'sd0, 16'sd0};
            5:  ang = '{16'sd0, 16'sd32767, 16'sd0};
            6:  ang = '{16'sd0, 16'sh8000, 16'sd0};
            7:  ang = '{16'sd0, 16'sd0, 16'sd32767};
            8:  ang = '{16'sd0, 16'sd0, 16'sh8000};
            // just inside and just past the fold, both signs
            9:  ang = '{16'sd25735, 16'sd0, 16'sd0};
            10: ang = '{16'sd25736, 16'sd0, 16'sd0};
            11: ang = '{-16'sd25735, 16'sd0, 16'sd0};
            12: ang = '{-16'sd25736, 16'sd0, 16'sd0};
            13: ang = '{16'sd0, 16'sd25736, -16'sd25736};
            14: ang = '{16'sd12868, 16'sd12868, 16'sd12868};
            15: ang = '{-16'sd12868, 16'sd12868, -16'sd12868};
            16: ang = '{16'sd1, -16'sd1, 16'sd1};
            17: ang = '{-16'sd1, 16'sd1, -16'sd1};
            18: ang = '{16'sd16384, -16'sd16384, 16'sd8192};
            default: ang = '{16'sd32767, 16'sh8000, 16'sd25736};
        endcase
        return ang;
    endfunction

    // offer one angle beat, optionally after a few idle cycles, and hold it until taken
    task automatic send_angles(input t_angles ang);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ang;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        quat_board.note_angles(ang);
    endtask

    initial begin : stimulus
        t_angles ang;
        int      drain_wait;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 20; k++)
            send_angles(corner_angles(k));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                ang.roll_angle  = random_angle();
                ang.pitch_angle = random_angle();
                ang.yaw_angle   = random_angle();
                send_angles(ang);
            end
            // after the first two phases the sender pauses until the pipeline has emptied
            if (phase < 2) begin
                i_in_valid <= 1'b0;
                while (quat_board.expected_quats.size() != 0)
                    @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        drain_wait = 0;
        while (quat_board.expected_quats.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        if (quat_board.expected_quats.size() != 0) begin
            $error("%0d quaternion beats never came out", quat_board.expected_quats.size());
            quat_board.mismatches++;
        end
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        if (quat_board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
